FILE: hw/rtl/csh_pkg.sv
// package: sizes, codes and control types shared by the circle/edge hit test block
`default_nettype none
package csh_pkg;

  localparam int MAX_EDGES  = 64;
  localparam int COORD_BITS = 24;

  localparam int ADDR_W     = $clog2(MAX_EDGES);
  localparam int CNT_W      = $clog2(MAX_EDGES + 1);
  localparam int IDX_W      = 6;
  localparam int EC_W       = 7;
  localparam int R_W        = 12;
  localparam int OFF_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [R_W-1:0]   RADIUS_RST = R_W'(128);
  localparam logic [OFF_W-1:0] OFFSET_RST = OFF_W'(128);

  // datapath widths
  localparam int C_W    = ((COORD_BITS > OFF_W) ? COORD_BITS : OFF_W + 1) + 1;
  localparam int W_W    = C_W + 1;
  localparam int E_W    = COORD_BITS + 1;
  localparam int P_W    = W_W + E_W;
  localparam int D_W    = P_W + 1;
  localparam int PL_W   = 2 * E_W;
  localparam int L_W    = 2 * COORD_BITS + 1;
  localparam int SQ_W   = COORD_BITS + R_W + 1;
  localparam int SQ_LO  = SQ_W / 2;
  localparam int SQ_HI  = SQ_W - SQ_LO;
  localparam int HH_W   = 2 * SQ_HI;
  localparam int HL_W   = SQ_HI + SQ_LO;
  localparam int LL_W   = 2 * SQ_LO;
  localparam int SS_W   = 2 * SQ_W;
  localparam int R2_W   = 2 * R_W;
  localparam int L_LO   = L_W / 2;
  localparam int L_HI   = L_W - L_LO;
  localparam int RLH_W  = R2_W + L_HI;
  localparam int RLL_W  = R2_W + L_LO;
  localparam int RL_W   = R2_W + L_W;
  localparam int RAM_W  = 4 * COORD_BITS;
  localparam int PIPE_N = 6;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TEST = 1'b1
  } csh_req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EDGE_COUNT    = 2'd0,
    CFG_CIRCLE_RADIUS = 2'd1,
    CFG_CENTRE_OFFSET = 2'd2
  } csh_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_HOLD
  } csh_state_t;

  typedef struct packed {
    logic              clear;
    logic              issue;
    logic [ADDR_W-1:0] issue_addr;
    logic              ram_we;
    logic              out_load;
    logic              out_is_test;
  } csh_cmd_t;

  typedef struct packed {
    logic hit_found;
    logic busy;
  } csh_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/csh_if.sv
// interfaces: request channel and result channel
`default_nettype none
interface csh_req_if;
  import csh_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [IDX_W-1:0]             edge_index;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] bullet_x;
  logic signed [COORD_BITS-1:0] bullet_y;

  modport source (output valid, req_type, edge_index, start_x, start_y, end_x, end_y,
                  bullet_x, bullet_y, input ready);
  modport sink (input valid, req_type, edge_index, start_x, start_y, end_x, end_y,
                bullet_x, bullet_y, output ready);
endinterface

interface csh_rsp_if;
  import csh_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [IDX_W-1:0] hit_edge;

  modport source (output valid, hit, hit_edge, input ready);
  modport sink (input valid, hit, hit_edge, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/csh_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module csh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/csh_ctrl.sv
// controller: item sequencing, edge issue counter, edge count register, output valid
`default_nettype none
module csh_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req_type,
  input  logic [csh_pkg::IDX_W-1:0]    in_edge_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         cfg_we,
  input  logic [csh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csh_pkg::CFG_DATA_W-1:0] cfg_data,
  output csh_pkg::csh_cmd_t            cmd,
  input  csh_pkg::csh_sts_t            sts
);
  import csh_pkg::*;

  csh_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] cnt_inc;
  logic [EC_W-1:0]  edge_count_r;
  logic             is_test_r, is_test_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             acc;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign acc       = in_valid && (state_r == ST_IDLE);
  assign lim       = (int'(edge_count_r) > MAX_EDGES) ? CNT_W'(MAX_EDGES)
                                                      : CNT_W'(edge_count_r);
  assign cnt_inc   = cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      is_test_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      edge_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      is_test_r   <= is_test_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == CFG_EDGE_COUNT)) begin
        edge_count_r <= cfg_data[EC_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    is_test_nxt     = is_test_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    cmd             = '0;
    cmd.issue_addr  = cnt_r[ADDR_W-1:0];
    cmd.out_is_test = is_test_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          cnt_nxt = '0;
          if (in_req_type == REQ_TEST) begin
            cmd.clear   = 1'b1;
            is_test_nxt = 1'b1;
            state_nxt   = (lim == '0) ? ST_HOLD : ST_SCAN;
          end else begin
            cmd.ram_we  = (int'(in_edge_index) < MAX_EDGES);
            is_test_nxt = 1'b0;
            state_nxt   = ST_HOLD;
          end
        end
      end
      ST_SCAN: begin
        if (sts.hit_found) begin
          state_nxt = ST_HOLD;
        end else begin
          cmd.issue = 1'b1;
          cnt_nxt   = cnt_inc;
          if (cnt_inc == lim) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (sts.hit_found || !sts.busy) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/csh_dpath.sv
// datapath: edge store, six-stage edge test pipeline, first-hit capture, result register
`default_nettype none
module csh_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  csh_pkg::csh_cmd_t                 cmd,
  output csh_pkg::csh_sts_t                 sts,
  input  logic                              cfg_we,
  input  logic [csh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csh_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [csh_pkg::IDX_W-1:0]         in_edge_index,
  input  logic signed [csh_pkg::COORD_BITS-1:0] in_start_x,
  input  logic signed [csh_pkg::COORD_BITS-1:0] in_start_y,
  input  logic signed [csh_pkg::COORD_BITS-1:0] in_end_x,
  input  logic signed [csh_pkg::COORD_BITS-1:0] in_end_y,
  input  logic signed [csh_pkg::COORD_BITS-1:0] in_bullet_x,
  input  logic signed [csh_pkg::COORD_BITS-1:0] in_bullet_y,
  output logic                              out_hit,
  output logic [csh_pkg::IDX_W-1:0]         out_hit_edge
);
  import csh_pkg::*;

  // config
  logic [R_W-1:0]   radius_r;
  logic [OFF_W-1:0] offset_r;
  logic [R2_W-1:0]  r2_r;

  // circle centre
  logic signed [C_W-1:0] off_ext;
  logic signed [C_W-1:0] cx_r, cy_r;

  // edge store
  logic [RAM_W-1:0] rd_data;
  logic signed [COORD_BITS-1:0] rd_sx, rd_sy, rd_ex, rd_ey;

  // pipeline control
  logic [PIPE_N-1:0] vld_r;
  logic [ADDR_W-1:0] idx_r [PIPE_N];

  // stage 1: differences
  logic signed [E_W-1:0] ex_r, ey_r;
  logic signed [W_W-1:0] wx_r, wy_r;
  // stage 2: products
  logic signed [P_W-1:0]  pd1_r, pd2_r, pc1_r, pc2_r;
  logic signed [PL_W-1:0] pl1_r, pl2_r;
  // stage 3: dot, length, cross magnitude
  logic signed [D_W-1:0] d_nxt, d_r, cp, cn;
  logic [PL_W-1:0]       lsum;
  logic [L_W-1:0]        len_r;
  logic [D_W-1:0]        cab_r;
  // stage 4: range flags and partial products
  logic              ok4_r;
  logic [HH_W-1:0]   hh_r;
  logic [HL_W-1:0]   hl_r;
  logic [LL_W-1:0]   ll_r;
  logic [RLH_W-1:0]  rlh_r;
  logic [RLL_W-1:0]  rll_r;
  logic [SQ_HI-1:0]  chi;
  logic [SQ_LO-1:0]  clo;
  logic [L_HI-1:0]   lhi;
  logic [L_LO-1:0]   llo;
  logic              dpos, dle, big;
  // stage 5: squared cross vs r^2 * len
  logic              ok5_r;
  logic [SS_W-1:0]   sq_r;
  logic [RL_W-1:0]   rl_r;
  logic              hit_now;

  // first hit
  logic              hit_found_r;
  logic [ADDR_W-1:0] hit_idx_r;

  assign off_ext = C_W'($signed({1'b0, offset_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      offset_r <= OFFSET_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CIRCLE_RADIUS) begin
        radius_r <= cfg_data[R_W-1:0];
      end
      if (cfg_index == CFG_CENTRE_OFFSET) begin
        offset_r <= cfg_data[OFF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    r2_r <= R2_W'(radius_r) * R2_W'(radius_r);
    if (cmd.clear) begin
      cx_r <= C_W'(in_bullet_x) + off_ext;
      cy_r <= C_W'(in_bullet_y) + off_ext;
    end
  end

  csh_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_EDGES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (ADDR_W'(in_edge_index)),
    .wdata ({in_start_x, in_start_y, in_end_x, in_end_y}),
    .raddr (cmd.issue_addr),
    .rdata (rd_data)
  );

  assign rd_sx = rd_data[4*COORD_BITS-1:3*COORD_BITS];
  assign rd_sy = rd_data[3*COORD_BITS-1:2*COORD_BITS];
  assign rd_ex = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign rd_ey = rd_data[COORD_BITS-1:0];

  // valid and index travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_N-2:0], cmd.issue};
    end
  end

  always_ff @(posedge clk) begin
    idx_r[0] <= cmd.issue_addr;
    for (int i = 1; i < PIPE_N; i++) begin
      idx_r[i] <= idx_r[i-1];
    end
  end

  // stage 3 combinational: one add each, abs by parallel subtract
  assign d_nxt = D_W'(pd1_r) + D_W'(pd2_r);
  assign cp    = D_W'(pc1_r) - D_W'(pc2_r);
  assign cn    = D_W'(pc2_r) - D_W'(pc1_r);
  assign lsum  = PL_W'(pl1_r) + PL_W'(pl2_r);

  // stage 4 combinational
  assign dpos = !d_r[D_W-1] && (d_r != '0);
  assign dle  = d_r <= $signed(D_W'(len_r));
  assign big  = |cab_r[D_W-1:SQ_W];
  assign chi  = cab_r[SQ_W-1:SQ_LO];
  assign clo  = cab_r[SQ_LO-1:0];
  assign lhi  = len_r[L_W-1:L_LO];
  assign llo  = len_r[L_LO-1:0];

  always_ff @(posedge clk) begin
    // stage 1
    ex_r  <= E_W'(rd_ex) - E_W'(rd_sx);
    ey_r  <= E_W'(rd_ey) - E_W'(rd_sy);
    wx_r  <= W_W'(cx_r) - W_W'(rd_sx);
    wy_r  <= W_W'(cy_r) - W_W'(rd_sy);
    // stage 2
    pd1_r <= P_W'(wx_r) * P_W'(ex_r);
    pd2_r <= P_W'(wy_r) * P_W'(ey_r);
    pc1_r <= P_W'(wx_r) * P_W'(ey_r);
    pc2_r <= P_W'(wy_r) * P_W'(ex_r);
    pl1_r <= PL_W'(ex_r) * PL_W'(ex_r);
    pl2_r <= PL_W'(ey_r) * PL_W'(ey_r);
    // stage 3
    d_r   <= d_nxt;
    len_r <= lsum[L_W-1:0];
    cab_r <= cp[D_W-1] ? cn : cp;
    // stage 4
    ok4_r <= dpos && dle && !big;
    hh_r  <= HH_W'(chi) * HH_W'(chi);
    hl_r  <= HL_W'(chi) * HL_W'(clo);
    ll_r  <= LL_W'(clo) * LL_W'(clo);
    rlh_r <= RLH_W'(r2_r) * RLH_W'(lhi);
    rll_r <= RLL_W'(r2_r) * RLL_W'(llo);
    // stage 5
    ok5_r <= ok4_r;
    sq_r  <= (SS_W'(hh_r) << (2 * SQ_LO)) + (SS_W'(hl_r) << (SQ_LO + 1)) + SS_W'(ll_r);
    rl_r  <= (RL_W'(rlh_r) << L_LO) + RL_W'(rll_r);
  end

  assign hit_now = vld_r[PIPE_N-1] && ok5_r && (sq_r < SS_W'(rl_r));

  // edges arrive in order, so the first capture is the first hit
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      hit_found_r <= 1'b0;
    end else if (hit_now && !hit_found_r) begin
      hit_found_r <= 1'b1;
    end
    if (hit_now && !hit_found_r) begin
      hit_idx_r <= idx_r[PIPE_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit      <= cmd.out_is_test && hit_found_r;
      out_hit_edge <= (cmd.out_is_test && hit_found_r) ? IDX_W'(hit_idx_r) : '0;
    end
  end

  assign sts.hit_found = hit_found_r;
  assign sts.busy      = |vld_r;

endmodule
`default_nettype wire

FILE: hw/rtl/circle_segment_hit_test.sv
// top level: circle against stored wall edges, first-hit report
// load item: the edge is written at the accept edge; the result then goes from the hold state into the output register
// test item: walks n = min(edge_count, 64) edges, none when n is 0, and stops early
//   on a hit; one edge enters the six-stage test pipeline per cycle,
//   so the edge walk sets the rate
// one item in work at a time; a finished result waits in the output register while
//   the next item is accepted
// reset (synchronous, rst_n low): control, edge_count 0, radius and offset 128;
//   the edge store is not cleared
`default_nettype none
module circle_segment_hit_test (
  input  logic                           clk,
  input  logic                           rst_n,
  csh_req_if.sink                        in_req,
  csh_rsp_if.source                      out_rsp,
  input  logic                           cfg_we,
  input  logic [csh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import csh_pkg::*;

  // command and status between sequencer and datapath
  csh_cmd_t cmd;
  csh_sts_t sts;

  // sequencer: accepts items, walks the edge list, hands results out
  csh_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_req.valid),
    .in_ready      (in_req.ready),
    .in_req_type   (in_req.req_type),
    .in_edge_index (in_req.edge_index),
    .out_valid     (out_rsp.valid),
    .out_ready     (out_rsp.ready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts)
  );

  // datapath: edge store, exact integer test, first-hit capture, result payload
  csh_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_edge_index (in_req.edge_index),
    .in_start_x    (in_req.start_x),
    .in_start_y    (in_req.start_y),
    .in_end_x      (in_req.end_x),
    .in_end_y      (in_req.end_y),
    .in_bullet_x   (in_req.bullet_x),
    .in_bullet_y   (in_req.bullet_y),
    .out_hit       (out_rsp.hit),
    .out_hit_edge  (out_rsp.hit_edge)
  );

endmodule
`default_nettype wire

FILE: tb/circle_segment_hit_test_test.sv
// testbench for circle_segment_hit_test: directed rows and random phases checked against a predictor
module circle_segment_hit_test_test;
  import csh_pkg::*;

  localparam int C_HI = 2 ** (COORD_BITS - 1) - 1;
  localparam int C_LO = -(2 ** (COORD_BITS - 1));
  // index 3 maps to no register
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASES = 12;
  localparam int MIXED_PER_PHASE = 30;

  // one request item as the sender sees it
  typedef struct {
    csh_req_t                     kind;
    logic [IDX_W-1:0]             slot;
    logic signed [COORD_BITS-1:0] sx, sy, ex, ey, bx, by;
  } wall_req_t;

  // one result item
  typedef struct {
    logic             hit;
    logic [IDX_W-1:0] seg;
  } hit_rsp_t;

  // directed rows are either an item or a register write
  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             what;
    wall_req_t             req;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  known;
    hit_rsp_t              rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  csh_req_if in_req ();
  csh_rsp_if out_rsp ();

  circle_segment_hit_test i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // synchronous reset, low from the start and released once
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // generous cap on the whole run
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // predictor copy of the edge store and the registers
  logic signed [COORD_BITS-1:0] seg_sx [MAX_EDGES];
  logic signed [COORD_BITS-1:0] seg_sy [MAX_EDGES];
  logic signed [COORD_BITS-1:0] seg_ex [MAX_EDGES];
  logic signed [COORD_BITS-1:0] seg_ey [MAX_EDGES];
  logic [EC_W-1:0]  m_count  = '0;
  logic [R_W-1:0]   m_radius = RADIUS_RST;
  logic [OFF_W-1:0] m_offset = OFFSET_RST;

  // results still owed by the block, oldest first
  hit_rsp_t pending_hits[$];
  int errors = 0;

  // idling controls for sender and receiver
  logic calm = 1'b0;
  logic req_idle_on = 1'b1;
  logic rsp_idle_on = 1'b1;
  logic long_hold = 1'b0;

  // region that the current random phase lives in
  int base_x = 0;
  int base_y = 0;

  // exact first-hit search; loads update the store and answer with no hit
  function automatic hit_rsp_t predict_hit(wall_req_t r);
    hit_rsp_t res;
    logic signed [159:0] cx, cy, wx, wy, vx, vy, dot, len, dist2, r2;
    int n;
    res.hit = 1'b0;
    res.seg = '0;
    if (r.kind == REQ_LOAD) begin
      seg_sx[r.slot] = r.sx;
      seg_sy[r.slot] = r.sy;
      seg_ex[r.slot] = r.ex;
      seg_ey[r.slot] = r.ey;
    end else begin
      // edge count above the store size saturates
      n = (m_count > MAX_EDGES) ? MAX_EDGES : int'(m_count);
      cx = r.bx + $signed({1'b0, m_offset});
      cy = r.by + $signed({1'b0, m_offset});
      r2 = $signed({1'b0, m_radius}) * $signed({1'b0, m_radius});
      for (int k = 0; k < n && !res.hit; k++) begin
        vx = seg_ex[k] - seg_sx[k];
        vy = seg_ey[k] - seg_sy[k];
        wx = cx - seg_sx[k];
        wy = cy - seg_sy[k];
        dot = wx * vx + wy * vy;
        len = vx * vx + vy * vy;
        dist2 = wx * wx + wy * wy;
        // foot strictly past start, at or before end, perpendicular distance below radius
        if (dot > 0 && dot <= len && dist2 * len - dot * dot < r2 * len) begin
          res.hit = 1'b1;
          res.seg = IDX_W'(k);
        end
      end
    end
    return res;
  endfunction

  function automatic int spread(int s);
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] clip(int v);
    if (v > C_HI) return COORD_BITS'(C_HI);
    if (v < C_LO) return COORD_BITS'(C_LO);
    return COORD_BITS'(v);
  endfunction

  // unused fields still carry random bits
  function automatic wall_req_t noise_req();
    wall_req_t r;
    r.kind = csh_req_t'($urandom_range(0, 1));
    r.slot = IDX_W'($urandom());
    r.sx = COORD_BITS'($urandom());
    r.sy = COORD_BITS'($urandom());
    r.ex = COORD_BITS'($urandom());
    r.ey = COORD_BITS'($urandom());
    r.bx = COORD_BITS'($urandom());
    r.by = COORD_BITS'($urandom());
    return r;
  endfunction

  // short edge inside the current region, now and then degenerate
  function automatic wall_req_t region_load(int slot);
    wall_req_t r;
    int x0, y0;
    r = noise_req();
    x0 = base_x + spread(6000);
    y0 = base_y + spread(6000);
    r.kind = REQ_LOAD;
    r.slot = IDX_W'(slot);
    r.sx = clip(x0);
    r.sy = clip(y0);
    if ($urandom_range(0, 15) == 0) begin
      r.ex = r.sx;
      r.ey = r.sy;
    end else begin
      r.ex = clip(x0 + spread(3000));
      r.ey = clip(y0 + spread(3000));
    end
    return r;
  endfunction

  // bullet whose centre lands near some tested edge, a little past either end at times
  function automatic wall_req_t near_test(int live);
    wall_req_t r;
    int k, t, px, py, j;
    r = noise_req();
    r.kind = REQ_TEST;
    j = 2 * int'(m_radius) + 16;
    if (live == 0) begin
      px = base_x + spread(8000);
      py = base_y + spread(8000);
    end else begin
      k = $urandom_range(0, live - 1);
      t = int'($urandom_range(0, 20)) - 2;
      px = int'(seg_sx[k]) + (int'(seg_ex[k]) - int'(seg_sx[k])) * t / 16;
      py = int'(seg_sy[k]) + (int'(seg_ey[k]) - int'(seg_sy[k])) * t / 16;
    end
    r.bx = clip(px + spread(j) - int'(m_offset));
    r.by = clip(py + spread(j) - int'(m_offset));
    return r;
  endfunction

  // directed row builders
  function automatic dir_row_t row_load(int slot, int sx, int sy, int ex, int ey);
    dir_row_t d;
    d.what = ROW_ITEM;
    d.req = noise_req();
    d.req.kind = REQ_LOAD;
    d.req.slot = IDX_W'(slot);
    d.req.sx = COORD_BITS'(sx);
    d.req.sy = COORD_BITS'(sy);
    d.req.ex = COORD_BITS'(ex);
    d.req.ey = COORD_BITS'(ey);
    d.reg_idx = '0;
    d.reg_val = '0;
    d.known = 1'b1;
    d.rsp.hit = 1'b0;
    d.rsp.seg = '0;
    return d;
  endfunction

  function automatic dir_row_t row_test(int bx, int by, logic known);
    dir_row_t d;
    d.what = ROW_ITEM;
    d.req = noise_req();
    d.req.kind = REQ_TEST;
    d.req.bx = COORD_BITS'(bx);
    d.req.by = COORD_BITS'(by);
    d.reg_idx = '0;
    d.reg_val = '0;
    // only the no-hit answers are typed in
    d.known = known;
    d.rsp.hit = 1'b0;
    d.rsp.seg = '0;
    return d;
  endfunction

  function automatic dir_row_t row_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t d;
    d = row_test(0, 0, 1'b0);
    d.what = ROW_REG;
    d.reg_idx = idx;
    d.reg_val = val;
    return d;
  endfunction

  // offer one item, record what it should produce, then maybe go quiet for a burst
  task automatic offer(wall_req_t r, logic known, hit_rsp_t fixed);
    hit_rsp_t want;
    in_req.valid      <= 1'b1;
    in_req.req_type   <= r.kind;
    in_req.edge_index <= r.slot;
    in_req.start_x    <= r.sx;
    in_req.start_y    <= r.sy;
    in_req.end_x      <= r.ex;
    in_req.end_y      <= r.ey;
    in_req.bullet_x   <= r.bx;
    in_req.bullet_y   <= r.by;
    do @(posedge clk); while (!in_req.ready);
    // always run the predictor so the store follows the loads
    want = predict_hit(r);
    pending_hits.push_back(known ? fixed : want);
    if (!calm && req_idle_on && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every owed result has come back
  task automatic drain();
    in_req.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  // one register write, strobe low again on the following edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_EDGE_COUNT:    m_count  = val[EC_W-1:0];
      CFG_CIRCLE_RADIUS: m_radius = val[R_W-1:0];
      CFG_CENTRE_OFFSET: m_offset = val[OFF_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // result receiver: random stall bursts, one long hold-off on request
  initial begin
    out_rsp.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold) begin
        // block fills and must stall its input
        out_rsp.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm && rsp_idle_on && $urandom_range(0, 5) == 0) begin
        out_rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin : check_rsp
    hit_rsp_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hit %0b edge %0d",
                 $time, out_rsp.hit, out_rsp.hit_edge);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (out_rsp.hit !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, out_rsp.hit);
          errors++;
        end
        if (out_rsp.hit_edge !== want.seg) begin
          $display("%0t: hit_edge mismatch, expected %0d, actual %0d",
                   $time, want.seg, out_rsp.hit_edge);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin : drive_items
    dir_row_t  rows[$];
    wall_req_t r;
    hit_rsp_t  no_rsp;
    int ec, rad, off, live, pick;

    in_req.valid      <= 1'b0;
    in_req.req_type   <= REQ_LOAD;
    in_req.edge_index <= '0;
    in_req.start_x    <= '0;
    in_req.start_y    <= '0;
    in_req.end_x      <= '0;
    in_req.end_y      <= '0;
    in_req.bullet_x   <= '0;
    in_req.bullet_y   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    no_rsp.hit = 1'b0;
    no_rsp.seg = '0;
    do @(posedge clk); while (!rst_n);

    // edge count is 0 after reset, so nothing can hit, even at the coordinate extremes
    rows.push_back(row_test(0, 0, 1'b1));
    rows.push_back(row_test(C_HI, C_HI, 1'b1));
    rows.push_back(row_test(C_LO, C_LO, 1'b1));
    // horizontal edge, degenerate edge, both full-range diagonals, the top slot
    rows.push_back(row_load(0, 0, 0, 1600, 0));
    rows.push_back(row_load(1, 400, 400, 400, 400));
    rows.push_back(row_load(2, C_LO, C_LO, C_HI, C_HI));
    rows.push_back(row_load(3, C_HI, C_LO, C_LO, C_HI));
    rows.push_back(row_load(MAX_EDGES - 1, C_HI, C_HI, C_LO, C_LO));
    rows.push_back(row_reg(CFG_EDGE_COUNT, 12'd4));
    // centre over the middle of edge 0, at distance 50, below the radius
    rows.push_back(row_test(800 - 128, 50 - 128, 1'b0));
    // foot exactly on the end of edge 0
    rows.push_back(row_test(1600 - 128, -128, 1'b0));
    // foot exactly on the start of edge 0: not counted, the diagonal catches it
    rows.push_back(row_test(-128, 60 - 128, 1'b0));
    // on top of the degenerate edge
    rows.push_back(row_test(400 - 128, 400 - 128, 1'b0));
    // zero radius: a centre right on an edge still misses
    rows.push_back(row_reg(CFG_CIRCLE_RADIUS, 12'd0));
    rows.push_back(row_test(800 - 128, -128, 1'b1));
    // write to an unmapped index changes nothing
    rows.push_back(row_reg(CFG_UNMAPPED, 12'hFFF));
    rows.push_back(row_test(800 - 128, -128, 1'b1));
    rows.push_back(row_reg(CFG_CIRCLE_RADIUS, 12'hFFF));
    rows.push_back(row_reg(CFG_CENTRE_OFFSET, 12'hFFF));
    rows.push_back(row_test(C_HI, C_HI, 1'b0));
    rows.push_back(row_test(C_LO, C_LO, 1'b0));
    rows.push_back(row_reg(CFG_CENTRE_OFFSET, 12'd0));
    // only the low 7 bits of the count are kept: edge 0 alone
    rows.push_back(row_reg(CFG_EDGE_COUNT, 12'hF81));
    rows.push_back(row_test(0, 60, 1'b0));
    rows.push_back(row_test(800, 4000, 1'b0));

    foreach (rows[i]) begin
      if (rows[i].what == ROW_REG) begin
        drain();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        offer(rows[i].req, rows[i].known, rows[i].rsp);
      end
    end

    // random phases: new registers and a new region each, edges loaded before any test
    for (int p = 0; p < PHASES; p++) begin
      drain();
      calm = (p >= PHASES - 2);
      req_idle_on = (p % 3 != 2);
      rsp_idle_on = (p % 4 != 1);
      case (p)
        0: ec = 0;
        1: ec = 1;
        2: ec = 2;
        3: ec = MAX_EDGES;
        4: ec = 127;
        default: ec = $urandom_range(3, 20);
      endcase
      case (p)
        1: rad = 0;
        2: rad = 4095;
        5: rad = 1;
        default: rad = $urandom_range(32, 700);
      endcase
      case (p)
        3: off = 0;
        4: off = 4095;
        default: off = $urandom_range(0, 4095);
      endcase
      write_reg(CFG_EDGE_COUNT, CFG_DATA_W'(ec));
      write_reg(CFG_CIRCLE_RADIUS, CFG_DATA_W'(rad));
      write_reg(CFG_CENTRE_OFFSET, CFG_DATA_W'(off));
      live = (ec > MAX_EDGES) ? MAX_EDGES : ec;
      base_x = spread(C_HI - 100000);
      base_y = spread(C_HI - 100000);
      // receiver goes quiet while the region loads keep coming
      if (p == 6) long_hold = 1'b1;
      for (int s = 0; s < live; s++) offer(region_load(s), 1'b0, no_rsp);
      for (int i = 0; i < MIXED_PER_PHASE; i++) begin
        // sender waits for everything owed before going on
        if (p == 7 && i == MIXED_PER_PHASE / 2) drain();
        pick = $urandom_range(0, 9);
        if (pick < 2) r = region_load($urandom_range(0, MAX_EDGES - 1));
        else if (pick == 2) r = noise_req();
        else r = near_test(live);
        offer(r, 1'b0, no_rsp);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
